/* hw/rtl/assert_macros.svh */
// assertion macros shared by the receiver rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hw/rtl/mfr_pkg.sv */
// types, constants and the morse tree table for the frame receiver
// no dependencies; used by mfr_walk and morse_frame_receiver
package mfr_pkg;

  localparam int HDR_START = 0;
  localparam int SYM_START = 4;
  localparam int KEY_W     = 5;
  localparam int LEN_W     = 3;
  localparam int LETTER_W  = 7;

  localparam logic [5:0]          ROOT_NODE = 6'd1;
  localparam logic [LETTER_W-1:0] ROOT_CHAR = 7'h40;

  localparam logic [7:0] DOT_LIMIT_RST  = 8'd20;
  localparam logic [7:0] DASH_LIMIT_RST = 8'd45;
  localparam logic [4:0] SYM_KEY_RST    = 5'd25;

  typedef enum logic [1:0] {
    REG_DOT_LIMIT  = 2'd0,
    REG_DASH_LIMIT = 2'd1,
    REG_SYM_KEY    = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    STATUS_LETTER  = 2'd0,
    STATUS_ROOT    = 2'd1,
    STATUS_END     = 2'd2,
    STATUS_CORRUPT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_EMIT = 2'd2
  } rx_state_t;

  // walker result, one cycle pulse on done
  typedef struct packed {
    logic                done;
    status_t             status;
    logic [LETTER_W-1:0] letter;
  } walk_res_t;

  // heap-ordered morse tree, zero marks a missing node
  function automatic logic [LETTER_W-1:0] tree_char(input logic [5:0] idx);
    logic [LETTER_W-1:0] c;
    case (idx)
      6'd1:    c = 7'h40;
      6'd2:    c = 7'h45;
      6'd3:    c = 7'h54;
      6'd4:    c = 7'h49;
      6'd5:    c = 7'h41;
      6'd6:    c = 7'h4E;
      6'd7:    c = 7'h4D;
      6'd8:    c = 7'h53;
      6'd9:    c = 7'h55;
      6'd10:   c = 7'h52;
      6'd11:   c = 7'h57;
      6'd12:   c = 7'h44;
      6'd13:   c = 7'h4B;
      6'd14:   c = 7'h47;
      6'd15:   c = 7'h4F;
      6'd16:   c = 7'h48;
      6'd17:   c = 7'h56;
      6'd18:   c = 7'h46;
      6'd19:   c = 7'h2A;
      6'd20:   c = 7'h4C;
      6'd21:   c = 7'h2F;
      6'd22:   c = 7'h50;
      6'd23:   c = 7'h4A;
      6'd24:   c = 7'h42;
      6'd25:   c = 7'h58;
      6'd26:   c = 7'h43;
      6'd27:   c = 7'h59;
      6'd28:   c = 7'h5A;
      6'd29:   c = 7'h51;
      6'd30:   c = 7'h2B;
      6'd31:   c = 7'h2D;
      6'd32:   c = 7'h35;
      6'd33:   c = 7'h34;
      6'd35:   c = 7'h33;
      6'd36:   c = 7'h5F;
      6'd39:   c = 7'h32;
      6'd47:   c = 7'h31;
      6'd48:   c = 7'h36;
      6'd49:   c = 7'h3D;
      6'd56:   c = 7'h37;
      6'd60:   c = 7'h38;
      6'd62:   c = 7'h39;
      6'd63:   c = 7'h30;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/mfr_walk.sv */
// morse tree walker: one symbol bit per cycle from a shift register
// depends on mfr_pkg for the tree table and result struct
module mfr_walk import mfr_pkg::*; #(
  parameter int SYMBOL_BITS = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [LEN_W-1:0]       len,
  input  logic [SYMBOL_BITS-1:0] symbols,
  output walk_res_t              res
);

  logic [5:0]             pos;
  logic [LEN_W-1:0]       steps;
  logic [SYMBOL_BITS-1:0] sym;
  logic                   done;
  logic [6:0]             next_node;
  logic [5:0]             pos_next;
  logic [LETTER_W-1:0]    pos_char;

  // one tree step: missing node or step past the last level goes to root
  always_comb begin
    next_node = {pos, sym[0]};
    if (next_node[6] || (tree_char(next_node[5:0]) == '0)) begin
      pos_next = ROOT_NODE;
    end else begin
      pos_next = next_node[5:0];
    end
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else if (start) begin
      steps <= len;
      done  <= 1'b0;
    end else begin
      done <= (steps == LEN_W'(1));
      if (steps != '0) begin
        steps <= steps - LEN_W'(1);
      end
    end
  end

  // node register and symbol shift register
  always_ff @(posedge clk) begin
    if (start) begin
      pos <= ROOT_NODE;
      sym <= symbols;
    end else if (steps != '0) begin
      pos <= pos_next;
      sym <= sym >> 1;
    end
  end

  // final node lookup
  always_comb begin
    pos_char   = tree_char(pos);
    res.done   = done;
    if (pos_char == ROOT_CHAR) begin
      res.status = STATUS_ROOT;
      res.letter = '0;
    end else begin
      res.status = STATUS_LETTER;
      res.letter = pos_char;
    end
  end

endmodule

/* hw/rtl/morse_frame_receiver.sv */
// pulse-width frame receiver with morse decode; line samples in, letters out
// one sample per cycle while no frame is being decoded. a completed frame holds
// the input through ST_EMIT (parity fail or end of message) or ST_WALK and ST_EMIT
// (tree walk, one symbol per cycle in mfr_walk), then the result sits in the output
// register. reset (synchronous) restores limits 20/45, key 25, and empties the frame.
module morse_frame_receiver import mfr_pkg::*; #(
  parameter int SYMBOL_BITS = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                line_high,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [LETTER_W-1:0] letter
);

`include "assert_macros.svh"

  localparam int FRAME_BITS = SYM_START + SYMBOL_BITS;
  localparam int CNT_W      = $clog2(FRAME_BITS);

  logic [7:0]             dot_limit;
  logic [7:0]             dash_limit;
  logic [KEY_W-1:0]       symbol_key;
  logic [7:0]             pulse_ticks;
  logic [CNT_W-1:0]       bits_received;
  logic [FRAME_BITS-1:0]  frame_store;
  logic                   parity;
  rx_state_t              state;
  rx_state_t              state_next;
  status_t                pend_status;
  logic [LETTER_W-1:0]    pend_letter;
  status_t                out_status;
  logic [LETTER_W-1:0]    out_letter;

  logic                   accept;
  logic                   pulse_end;
  logic                   bit_val;
  logic                   frame_done;
  logic [FRAME_BITS-1:0]  frame_full;
  logic                   parity_full;
  logic [LEN_W-1:0]       frame_len;
  logic [LEN_W-1:0]       walk_len;
  logic [SYMBOL_BITS-1:0] keyed_sym;
  logic                   walk_start;
  logic                   emit_load;
  walk_res_t              res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_limit  <= DOT_LIMIT_RST;
      dash_limit <= DASH_LIMIT_RST;
      symbol_key <= SYM_KEY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOT_LIMIT:  dot_limit  <= cfg_data;
        REG_DASH_LIMIT: dash_limit <= cfg_data;
        REG_SYM_KEY:    symbol_key <= cfg_data[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // pulse classification and frame assembly
  always_comb begin
    accept      = in_valid && in_ready;
    pulse_end   = accept && !line_high && (pulse_ticks != '0);
    bit_val     = (pulse_ticks > dot_limit) && (pulse_ticks < dash_limit);
    frame_full  = {bit_val, frame_store[FRAME_BITS-1:1]};
    parity_full = parity ^ bit_val;
    frame_done  = pulse_end && (bits_received == CNT_W'(FRAME_BITS - 1));
    frame_len   = {frame_full[HDR_START], frame_full[HDR_START+1], frame_full[HDR_START+2]};
    if ({1'b0, frame_len} > 4'(SYMBOL_BITS)) begin
      walk_len = LEN_W'(SYMBOL_BITS);
    end else begin
      walk_len = frame_len;
    end
  end

  // key the symbol bits, key msb goes with the first symbol
  for (genvar i = 0; i < SYMBOL_BITS; i++) begin : g_key
    if (SYMBOL_BITS - 1 - i < KEY_W) begin : g_xor
      assign keyed_sym[i] = frame_full[SYM_START+i] ^ symbol_key[SYMBOL_BITS-1-i];
    end else begin : g_pass
      assign keyed_sym[i] = frame_full[SYM_START+i];
    end
  end

  // tick counter, bit counter and running parity
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_ticks   <= '0;
      bits_received <= '0;
      parity        <= 1'b0;
    end else if (accept) begin
      if (line_high) begin
        if (pulse_ticks != 8'hFF) begin
          pulse_ticks <= pulse_ticks + 8'd1;
        end
      end else if (pulse_end) begin
        pulse_ticks <= '0;
        if (frame_done) begin
          bits_received <= '0;
          parity        <= 1'b0;
        end else begin
          bits_received <= bits_received + CNT_W'(1);
          parity        <= parity_full;
        end
      end
    end
  end

  // frame shift register, every slot is overwritten before use
  always_ff @(posedge clk) begin
    if (pulse_end) begin
      frame_store <= frame_full;
    end
  end

  mfr_walk #(
    .SYMBOL_BITS(SYMBOL_BITS)
  ) u_walk (
    .clk     (clk),
    .rst     (rst),
    .start   (walk_start),
    .len     (walk_len),
    .symbols (keyed_sym),
    .res     (res)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    walk_start = 1'b0;
    emit_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (frame_done) begin
          if (!parity_full && (frame_len != '0)) begin
            walk_start = 1'b1;
            state_next = ST_WALK;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_WALK: begin
        if (res.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          emit_load  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // pending result
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && frame_done) begin
      pend_status <= parity_full ? STATUS_CORRUPT : STATUS_END;
      pend_letter <= '0;
    end else if (state == ST_WALK && res.done) begin
      pend_status <= res.status;
      pend_letter <= res.letter;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_status <= pend_status;
      out_letter <= pend_letter;
    end
  end

  assign status = out_status;
  assign letter = out_letter;

  // checks
  `ASSERT_SAME(a_done_in_walk, clk, rst, res.done, state == ST_WALK)
  `ASSERT_NEXT(a_emit_fills, clk, rst, emit_load, out_valid && (state == ST_IDLE))
  `ASSERT_SAME(a_letter_only, clk, rst, out_valid && (out_status != STATUS_LETTER), letter == '0)
  `ASSERT_NEXT(a_walk_holds, clk, rst, walk_start, !in_ready)

endmodule

/* dv/tb_morse_frame_receiver.sv */
// self-checking testbench for morse_frame_receiver: line samples in, decoded letters out
// depends on mfr_pkg (status and register codes) and the morse_frame_receiver rtl
// directed frames from a table, then random frames over several limit and key settings
module tb_morse_frame_receiver;
  import mfr_pkg::*;

  localparam int SYM_BITS  = 5;
  localparam int FRAME_W   = SYM_START + SYM_BITS;
  localparam int LIMIT     = 500000;
  localparam int MIN_RAND_SAMPLES = 850;
  localparam int MIN_LETTERS      = 48;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic [7:0] NO_NODE   = ".";

  // morse tree in heap order, '.' marks a node that does not exist
  localparam logic [0:63][7:0] MORSE_HEAP = {
    ".@ETIANM", "SURWDKGO", "HVF*L/PJ", "BXCYZQ+-",
    "54.3_..2", ".......1", "6=......", "7...8.90"
  };

  // how the directed table shapes zero and one pulses
  typedef enum logic [1:0] {
    ZERO_SHORT, ZERO_AT_DOT, ZERO_AT_DASH, ZERO_SATURATED
  } zero_form_t;
  typedef enum logic {ONE_LOW, ONE_HIGH} one_form_t;

  typedef struct packed {
    logic [8:0]    bits;
    zero_form_t    zform;
    one_form_t     oform;
    logic          typed;
    status_t       st;
    logic [6:0]    ch;
  } frame_row_t;

  typedef struct packed {
    status_t     st;
    logic [6:0]  ch;
  } letter_result_t;

  typedef struct packed {
    logic [7:0] dot;
    logic [7:0] dash;
    logic [4:0] key;
    logic       spare;
    logic [7:0] wmax;
    logic [7:0] frames;
    logic       idle;
  } limit_phase_t;

  // frames at reset limits 20/45 and key 25
  localparam int N_ROWS = 13;
  localparam frame_row_t FRAME_ROWS [0:N_ROWS-1] = '{
    '{9'h000, ZERO_SHORT,     ONE_LOW,  1'b1, STATUS_END,     7'h00},
    '{9'h001, ZERO_SHORT,     ONE_LOW,  1'b1, STATUS_CORRUPT, 7'h00},
    '{9'h1FF, ZERO_SHORT,     ONE_HIGH, 1'b1, STATUS_CORRUPT, 7'h00},
    '{9'h014, ZERO_SHORT,     ONE_LOW,  1'b1, STATUS_LETTER,  "E"},
    '{9'h00C, ZERO_AT_DOT,    ONE_HIGH, 1'b1, STATUS_LETTER,  "T"},
    '{9'h0CF, ZERO_SHORT,     ONE_LOW,  1'b1, STATUS_LETTER,  "0"},
    '{9'h014, ZERO_AT_DASH,   ONE_HIGH, 1'b1, STATUS_LETTER,  "E"},
    '{9'h000, ZERO_SATURATED, ONE_LOW,  1'b1, STATUS_END,     7'h00},
    '{9'h1D5, ZERO_SHORT,     ONE_LOW,  1'b0, STATUS_LETTER,  7'h00},
    '{9'h0A5, ZERO_AT_DOT,    ONE_LOW,  1'b0, STATUS_LETTER,  7'h00},
    '{9'h132, ZERO_SHORT,     ONE_HIGH, 1'b0, STATUS_LETTER,  7'h00},
    '{9'h1E6, ZERO_AT_DASH,   ONE_LOW,  1'b0, STATUS_LETTER,  7'h00},
    '{9'h0F3, ZERO_SHORT,     ONE_HIGH, 1'b0, STATUS_LETTER,  7'h00}
  };

  // limit settings for the random part, the fourth and the last run without idling
  localparam int N_PHASES = 8;
  localparam limit_phase_t LIMIT_PHASES [0:N_PHASES-1] = '{
    '{8'd2,   8'd5,   5'h0A, 1'b0, 8'd6,  8'd10, 1'b1},
    '{8'd0,   8'd3,   5'h00, 1'b0, 8'd4,  8'd6,  1'b1},
    '{8'd255, 8'd0,   5'h1F, 1'b1, 8'd4,  8'd3,  1'b1},
    '{8'd1,   8'd255, 5'h15, 1'b0, 8'd8,  8'd5,  1'b0},
    '{8'd20,  8'd45,  5'h19, 1'b0, 8'd30, 8'd3,  1'b1},
    '{8'd3,   8'd1,   5'h1F, 1'b1, 8'd5,  8'd3,  1'b1},
    '{8'd4,   8'd9,   5'h00, 1'b0, 8'd6,  8'd10, 1'b1},
    '{8'd2,   8'd5,   5'h13, 1'b0, 8'd6,  8'd6,  1'b0}
  };

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       line_high = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] status;
  logic [LETTER_W-1:0] letter;

  // predictor state and its copy of the registers
  logic [7:0] dot_lim = DOT_LIMIT_RST;
  logic [7:0] dash_lim = DASH_LIMIT_RST;
  logic [4:0] sym_key = SYM_KEY_RST;
  logic [7:0] run_ticks = '0;
  logic [3:0] frame_len = '0;
  logic [FRAME_W-1:0] frame_acc = '0;

  letter_result_t pending_letters[$];
  letter_result_t oldest;
  logic           forced_on = 1'b0;
  letter_result_t forced_result;

  int  errors = 0;
  int  cycle_count = 0;
  int  rand_samples = 0;
  int  letters_expected = 0;
  int  out_hold = 0;
  int  width_cap = 6;
  bit  src_idle = 1'b1;
  bit  snk_idle = 1'b1;

  morse_frame_receiver dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .line_high(line_high),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .letter(letter)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver output stalls in random bursts while snk_idle is set
  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_ready <= (out_hold == 1);
    end else if (snk_idle && $urandom_range(0, 9) == 0) begin
      out_hold <= $urandom_range(1, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each result transfer with the oldest expected letter
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_letters.size() == 0) begin
        $display("%0t unexpected result: status %0d letter %h", $time, status, letter);
        errors++;
      end else begin
        oldest = pending_letters.pop_front();
        if (status !== oldest.st) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time, oldest.st, status);
          errors++;
        end
        if (letter !== oldest.ch) begin
          $display("%0t letter mismatch: expected %h actual %h", $time, oldest.ch, letter);
          errors++;
        end
      end
    end
  end

  // parity, keyed symbols and the tree walk for one complete frame
  function automatic letter_result_t decode_frame(input logic [FRAME_W-1:0] f);
    letter_result_t r;
    logic [LEN_W-1:0] len;
    logic [6:0] node;
    logic [6:0] nxt;
    logic s;
    int i;
    int k;
    r.st = STATUS_LETTER;
    r.ch = '0;
    node = {1'b0, ROOT_NODE};
    if (^f) begin
      r.st = STATUS_CORRUPT;
    end else begin
      len = {f[HDR_START], f[HDR_START+1], f[HDR_START+2]};
      if (len == 0) begin
        r.st = STATUS_END;
      end else begin
        if (len > SYM_BITS) len = SYM_BITS;
        for (i = 0; i < len; i++) begin
          s = f[SYM_START+i];
          k = SYM_BITS - 1 - i;
          if (k < KEY_W) s = s ^ sym_key[k];
          nxt = {node[5:0], s};
          if (nxt >= 64 || MORSE_HEAP[nxt[5:0]] == NO_NODE) node = {1'b0, ROOT_NODE};
          else node = nxt;
        end
        if (MORSE_HEAP[node[5:0]][6:0] == ROOT_CHAR) begin
          r.st = STATUS_ROOT;
        end else begin
          r.ch = MORSE_HEAP[node[5:0]][6:0];
        end
      end
    end
    return r;
  endfunction

  // pulse measurement and frame assembly for one accepted line sample
  task automatic track_line_sample(input logic hi);
    logic bitv;
    letter_result_t r;
    if (hi) begin
      if (run_ticks != 8'hFF) run_ticks++;
    end else if (run_ticks != 0) begin
      bitv = (run_ticks > dot_lim) && (run_ticks < dash_lim);
      run_ticks = '0;
      frame_acc[frame_len] = bitv;
      frame_len++;
      if (frame_len == FRAME_W) begin
        r = decode_frame(frame_acc);
        frame_acc = '0;
        frame_len = '0;
        if (forced_on) begin
          r = forced_result;
          forced_on = 1'b0;
        end
        pending_letters.push_back(r);
        letters_expected++;
      end
    end
  endtask

  // one sample transfer, with an optional idle burst ahead of it
  task automatic drive_sample(input logic hi);
    if (src_idle && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    line_high <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_line_sample(hi);
    rand_samples++;
  endtask

  // high run of the given length, then a low gap that ends the pulse
  task automatic drive_pulse(input int w);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
    repeat (w) drive_sample(1'b1);
    repeat (gap) drive_sample(1'b0);
  endtask

  // pulse length that should decode to the wanted bit under the current limits
  function automatic int bit_width(input logic b);
    int lo;
    int hi;
    if (b && dash_lim > dot_lim + 1) begin
      lo = dot_lim + 1;
      hi = (dash_lim - 1 < dot_lim + width_cap) ? dash_lim - 1 : dot_lim + width_cap;
      return $urandom_range(lo, hi);
    end
    if ($urandom_range(0, 63) == 0) return 256 + $urandom_range(0, 20);
    if (dot_lim >= 1 && $urandom_range(0, 3) != 0)
      return $urandom_range(1, (dot_lim < width_cap) ? dot_lim : width_cap);
    return ((dash_lim == 0) ? 1 : dash_lim) + $urandom_range(0, 2);
  endfunction

  function automatic int noise_width();
    if ($urandom_range(0, 49) == 0) return 256 + $urandom_range(0, 40);
    return $urandom_range(1, width_cap);
  endfunction

  function automatic int row_width(input logic b, input zero_form_t zf, input one_form_t of);
    if (b) return (of == ONE_LOW) ? dot_lim + 1 : dash_lim - 1;
    case (zf)
      ZERO_SHORT:   return 1;
      ZERO_AT_DOT:  return dot_lim;
      ZERO_AT_DASH: return dash_lim;
      default:      return 300;
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == REG_DOT_LIMIT) dot_lim = data;
    else if (idx == REG_DASH_LIMIT) dash_lim = data;
    else if (idx == REG_SYM_KEY) sym_key = data[4:0];
  endtask

  // drain all expected letters, then give the walker time to finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_letters.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    logic [FRAME_W-1:0] f;
    frame_row_t row;
    limit_phase_t ph;
    int r;
    int p;
    int i;
    int n;
    bit noisy;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed frames at reset limits
    for (r = 0; r < N_ROWS; r++) begin
      row = FRAME_ROWS[r];
      forced_on = row.typed;
      forced_result.st = row.st;
      forced_result.ch = row.ch;
      for (i = 0; i < FRAME_W; i++) drive_pulse(row_width(row.bits[i], row.zform, row.oform));
    end

    // random frames, one limit setting per phase
    rand_samples = 0;
    for (p = 0; p < N_PHASES; p++) begin
      ph = LIMIT_PHASES[p];
      wait_idle();
      write_reg(REG_DOT_LIMIT, ph.dot);
      write_reg(REG_DASH_LIMIT, ph.dash);
      write_reg(REG_SYM_KEY, {3'($urandom_range(0, 7)), ph.key});
      if (ph.spare) write_reg(REG_SPARE, 8'($urandom));
      cfg_we <= 1'b0;
      width_cap = ph.wmax;
      src_idle = ph.idle;
      snk_idle = ph.idle;
      n = 0;
      while (n < ph.frames ||
             (p == N_PHASES - 1 &&
              (rand_samples < MIN_RAND_SAMPLES || letters_expected < MIN_LETTERS))) begin
        f = 9'($urandom_range(0, 511));
        noisy = ($urandom_range(0, 7) == 0);
        // well-formed frames carry even parity through the spare header bit
        if (!noisy) f[3] = ^{f[8:4], f[2:0]};
        for (i = 0; i < FRAME_W; i++) drive_pulse(noisy ? noise_width() : bit_width(f[i]));
        n++;
      end
    end

    in_valid <= 1'b0;
    while (pending_letters.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/mfr_pkg.sv
hw/rtl/mfr_walk.sv
hw/rtl/morse_frame_receiver.sv
dv/tb_morse_frame_receiver.sv
